// File: src/lcdnf_pkg.sv
// lcdnf_pkg: shared codes, character constants and control/status structs
// for the character-LCD number formatter. No dependencies.
`default_nettype none

package lcdnf_pkg;

   // request modes
   localparam logic [2:0] MODE_UDEC = 3'd0;
   localparam logic [2:0] MODE_SDEC = 3'd1;
   localparam logic [2:0] MODE_HEX  = 3'd2;
   localparam logic [2:0] MODE_BIN  = 3'd3;
   localparam logic [2:0] MODE_CHAR = 3'd4;

   // display lines that get a cursor command
   localparam logic [1:0] LINE_ONE = 2'd1;
   localparam logic [1:0] LINE_TWO = 2'd2;

   // bus byte constants
   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
   localparam logic [7:0] LINE2_OFFSET  = 8'h40;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;

   // register select codes
   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   // reciprocal of ten, exact for 16-bit dividends after a shift of 19
   localparam logic [16:0] RECIP_TEN = 17'd52429;

   typedef enum logic [1:0] {
      SEL_CURSOR,
      SEL_SIGN,
      SEL_CHAR,
      SEL_DIGIT
   } byte_sel_type;

   typedef struct packed {
      logic         load;
      logic         extract;
      logic         emit;
      byte_sel_type sel;
      logic         last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic has_cursor;
      logic has_sign;
      logic is_char;
      logic no_digits;
      logic extract_done;
      logic last_digit;
   } dp_status_type;

endpackage

`default_nettype wire

// File: src/lcdnf_if.sv
// lcdnf_req_if / lcdnf_rsp_if: valid/ready channels for requests and bus bytes
// depends on nothing
`default_nettype none

interface lcdnf_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [1:0]  line;
   logic [4:0]  column;
   logic [15:0] number;
   logic [4:0]  digit_count;

   modport source (output valid, command, line, column, number, digit_count, input ready);
   modport sink   (input valid, command, line, column, number, digit_count, output ready);
endinterface

interface lcdnf_rsp_if;
   logic       valid;
   logic       ready;
   logic       reg_select;
   logic [7:0] bus_byte;
   logic       last;

   modport source (output valid, reg_select, bus_byte, last, input ready);
   modport sink   (input valid, reg_select, bus_byte, last, output ready);
endinterface

`default_nettype wire

// File: src/lcdnf_datapath.sv
// lcdnf_datapath: request registers, digit extraction unit, digit buffer
// and output byte register; depends on lcdnf_pkg
`default_nettype none

module lcdnf_datapath #(
   parameter int MAX_DIGITS = 16
) (
   input  wire logic                   clock,
   input  wire lcdnf_pkg::ctrl_cmd_type cmd,
   output      lcdnf_pkg::dp_status_type status,
   input  wire logic [2:0]             req_command,
   input  wire logic [1:0]             req_line,
   input  wire logic [4:0]             req_column,
   input  wire logic [15:0]            req_number,
   input  wire logic [4:0]             req_digit_count,
   output      logic                   rsp_reg_select,
   output      logic [7:0]             rsp_bus_byte,
   output      logic                   rsp_last
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [7:0]       cursor_ff, cursor_in;
   logic             has_cursor_ff, has_cursor_in;
   logic             has_sign_ff, has_sign_in;
   logic [7:0]       sign_ff, sign_in;
   logic             is_char_ff, is_char_in;
   logic [2:0]       mode_ff;
   logic [15:0]      value_ff, value_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] xcnt_ff;
   logic [CNT_W-1:0] ecnt_ff;
   logic [3:0]       digit_ff [MAX_DIGITS];
   logic             rs_ff;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff;

   logic [32:0]      prod;
   logic [15:0]      quot;
   logic [15:0]      rem_wide;
   logic [3:0]       rem;
   logic [CNT_W-1:0] ecnt_dec;
   logic [3:0]       rd_digit;
   logic [7:0]       col_m1;
   logic             mode_ok;

   // request decode
   always_comb begin
      mode_ok  = (req_command <= lcdnf_pkg::MODE_CHAR);
      col_m1   = {3'b000, req_column} - 8'd1;
      cursor_in = lcdnf_pkg::CMD_SET_DDRAM | col_m1;
      if (req_line == lcdnf_pkg::LINE_TWO) begin
         cursor_in = lcdnf_pkg::CMD_SET_DDRAM | (col_m1 + lcdnf_pkg::LINE2_OFFSET);
      end
      has_cursor_in = mode_ok &&
                      (req_line == lcdnf_pkg::LINE_ONE || req_line == lcdnf_pkg::LINE_TWO);
      is_char_in  = (req_command == lcdnf_pkg::MODE_CHAR);
      has_sign_in = (req_command == lcdnf_pkg::MODE_SDEC);
      sign_in     = req_number[15] ? lcdnf_pkg::CHAR_MINUS : lcdnf_pkg::CHAR_PLUS;
      value_in    = req_number;
      if (has_sign_in && req_number[15]) begin
         value_in = 16'd0 - req_number;
      end
      if (!mode_ok || is_char_in) begin
         count_in = '0;
      end else if (req_digit_count > 5'(MAX_DIGITS)) begin
         count_in = CNT_W'(MAX_DIGITS);
      end else begin
         count_in = CNT_W'(req_digit_count);
      end
   end

   // one digit per step
   always_comb begin
      prod     = value_ff * lcdnf_pkg::RECIP_TEN;
      quot     = {2'b00, prod[32:19]};
      rem_wide = value_ff - (quot << 3) - (quot << 1);
      rem      = rem_wide[3:0];
      case (mode_ff)
         lcdnf_pkg::MODE_HEX: begin
            quot = {4'b0000, value_ff[15:4]};
            rem  = value_ff[3:0];
         end
         lcdnf_pkg::MODE_BIN: begin
            quot = {1'b0, value_ff[15:1]};
            rem  = {3'b000, value_ff[0]};
         end
         default: begin
         end
      endcase
   end

   // output byte select
   always_comb begin
      ecnt_dec = ecnt_ff - CNT_W'(1);
      rd_digit = digit_ff[ecnt_dec[IDX_W-1:0]];
      case (cmd.sel)
         lcdnf_pkg::SEL_CURSOR: byte_in = cursor_ff;
         lcdnf_pkg::SEL_SIGN:   byte_in = sign_ff;
         lcdnf_pkg::SEL_CHAR:   byte_in = value_ff[7:0];
         default: begin
            if (rd_digit < 4'd10) begin
               byte_in = lcdnf_pkg::CHAR_ZERO + {4'b0000, rd_digit};
            end else begin
               byte_in = lcdnf_pkg::CHAR_UPPER_A + {4'b0000, rd_digit} - 8'd10;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cursor_ff     <= cursor_in;
         has_cursor_ff <= has_cursor_in;
         has_sign_ff   <= has_sign_in && mode_ok;
         sign_ff       <= sign_in;
         is_char_ff    <= is_char_in;
         mode_ff       <= req_command;
         value_ff      <= value_in;
         count_ff      <= count_in;
         xcnt_ff       <= '0;
         ecnt_ff       <= count_in;
      end else if (cmd.extract) begin
         digit_ff[xcnt_ff[IDX_W-1:0]] <= rem;
         value_ff <= quot;
         xcnt_ff  <= xcnt_ff + CNT_W'(1);
      end
      if (cmd.emit) begin
         rs_ff   <= (cmd.sel == lcdnf_pkg::SEL_CURSOR) ? lcdnf_pkg::RS_COMMAND
                                                       : lcdnf_pkg::RS_DATA;
         byte_ff <= byte_in;
         last_ff <= cmd.last;
         if (cmd.sel == lcdnf_pkg::SEL_DIGIT) begin
            ecnt_ff <= ecnt_dec;
         end
      end
   end

   always_comb begin
      status.has_cursor   = has_cursor_ff;
      status.has_sign     = has_sign_ff;
      status.is_char      = is_char_ff;
      status.no_digits    = (count_ff == '0);
      status.extract_done = (xcnt_ff == count_ff);
      status.last_digit   = (ecnt_ff == CNT_W'(1));
   end

   assign rsp_reg_select = rs_ff;
   assign rsp_bus_byte   = byte_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// File: src/lcdnf_ctrl.sv
// lcdnf_ctrl: sequencer for extraction and byte emission, owns the
// request ready and result valid; depends on lcdnf_pkg
`default_nettype none

module lcdnf_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire lcdnf_pkg::dp_status_type status,
   output      lcdnf_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXTRACT,
      ST_CURSOR,
      ST_SIGN,
      ST_CHAR,
      ST_DIGITS
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      cmd          = '0;
      cmd.sel      = lcdnf_pkg::SEL_DIGIT;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXTRACT;
            end
         end
         ST_EXTRACT: begin
            if (!status.extract_done) begin
               cmd.extract = 1'b1;
            end else if (status.has_cursor) begin
               state_in = ST_CURSOR;
            end else if (status.has_sign) begin
               state_in = ST_SIGN;
            end else if (status.is_char) begin
               state_in = ST_CHAR;
            end else if (!status.no_digits) begin
               state_in = ST_DIGITS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CURSOR: begin
            cmd.sel  = lcdnf_pkg::SEL_CURSOR;
            cmd.last = !status.has_sign && !status.is_char && status.no_digits;
            if (slot_free) begin
               cmd.emit = 1'b1;
               if (status.has_sign) begin
                  state_in = ST_SIGN;
               end else if (status.is_char) begin
                  state_in = ST_CHAR;
               end else if (!status.no_digits) begin
                  state_in = ST_DIGITS;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SIGN: begin
            cmd.sel  = lcdnf_pkg::SEL_SIGN;
            cmd.last = status.no_digits;
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = status.no_digits ? ST_IDLE : ST_DIGITS;
            end
         end
         ST_CHAR: begin
            cmd.sel  = lcdnf_pkg::SEL_CHAR;
            cmd.last = 1'b1;
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIGITS: begin
            cmd.sel  = lcdnf_pkg::SEL_DIGIT;
            cmd.last = status.last_digit;
            if (slot_free) begin
               cmd.emit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: src/char_lcd_number_formatter_unit.sv
// char_lcd_number_formatter_unit: turns one display request into a run of
// character-LCD bus bytes (cursor command, sign, digits or one character).
// steps: load the request, extract one digit per cycle with the single divide-by-base
//   unit, then emit one byte per cycle while the output is ready
// a new request is accepted only after the last byte of the previous one is emitted
// reset: synchronous active-high reset idles the sequencer and drops the output item
`default_nettype none

module char_lcd_number_formatter_unit #(
   parameter int MAX_DIGITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   lcdnf_req_if.sink   req_ch,
   lcdnf_rsp_if.source rsp_ch
);

   // command and status between sequencer and datapath
   lcdnf_pkg::ctrl_cmd_type  cmd;
   lcdnf_pkg::dp_status_type status;

   // sequencer: accepts an item only when idle, paces emission on rsp ready
   lcdnf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: captures the request, extracts digits low first into a
   // buffer, then reads them back high first into the output register
   lcdnf_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .req_command     (req_ch.command),
      .req_line        (req_ch.line),
      .req_column      (req_ch.column),
      .req_number      (req_ch.number),
      .req_digit_count (req_ch.digit_count),
      .rsp_reg_select  (rsp_ch.reg_select),
      .rsp_bus_byte    (rsp_ch.bus_byte),
      .rsp_last        (rsp_ch.last)
   );

endmodule

`default_nettype wire
